### rtl/ffcrc8_pkg.sv
package ffcrc8_pkg;

  localparam int FRAME_BYTES   = 10;
  localparam int PAYLOAD_BYTES = FRAME_BYTES - 1;
  localparam int BYTE_W        = 8;
  localparam int COUNT_W       = 6;
  localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int OUT_TDATA_W   = 16;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_READ,
    ST_SEND
  } state_t;

  // one table entry of the reflected crc-8, bit by bit
  function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] value);
    logic [BYTE_W-1:0] r;
    r = value;
    for (int k = 0; k < BYTE_W; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

### rtl/fixed_frame_crc8_receiver.sv
// fixed-length frame receiver with crc-8 check (reflected poly 0x8c, zero start)
// slave stream: one received byte per transfer on s_tdata
// master stream: payload bytes of a good frame, tlast on the final one;
//   a bad frame gives one transfer with tuser set, tdata zero and tlast set
// framing counts bytes since reset: FRAME_BYTES-1 payload bytes, then the crc
// payload bytes are taken one per cycle; the running crc is updated by the
// table function in the same cycle and the byte goes into the frame store
// on the crc byte the frame is checked: a bad frame shows its result on the
//   next cycle; a good frame is drained from the store by a read/send
//   sequencer, a read state then a send state per byte; a send waits until
//   the output register is free (one store read port, registered read data)
// s_tready is low while a frame drains, and for the crc byte while the
//   output register still holds an untaken result
// a stalled master side holds its result in the output register; payload
//   bytes of the next frame are still taken meanwhile
// rst (synchronous, active high) clears the byte count, the crc, the
//   sequencer and the output valid; the frame store is not cleared
module fixed_frame_crc8_receiver (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ffcrc8_pkg::BYTE_W-1:0]       s_tdata,   // rx_byte[7:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ffcrc8_pkg::OUT_TDATA_W-1:0]  m_tdata,   // payload_byte[7:0], byte_index[13:8]
  output logic                                m_tlast,   // last_of_frame
  output logic                                m_tuser    // crc_bad
);

  localparam int PAD_W = ffcrc8_pkg::OUT_TDATA_W - ffcrc8_pkg::BYTE_W - ffcrc8_pkg::COUNT_W;

  ffcrc8_pkg::state_t state, state_next;

  logic [ffcrc8_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [ffcrc8_pkg::BYTE_W-1:0]  running_crc, running_crc_next;
  logic [ffcrc8_pkg::ADDR_W-1:0]  rd_idx, rd_idx_next;
  logic [ffcrc8_pkg::BYTE_W-1:0]  rd_data;

  logic                           out_valid, out_valid_next;
  logic [ffcrc8_pkg::BYTE_W-1:0]  out_byte, out_byte_next;
  logic [ffcrc8_pkg::COUNT_W-1:0] out_index, out_index_next;
  logic                           out_last, out_last_next;
  logic                           out_bad, out_bad_next;

  logic [ffcrc8_pkg::BYTE_W-1:0] frame_store [ffcrc8_pkg::PAYLOAD_BYTES];

  logic is_final;
  logic out_free;
  logic in_xfer;
  logic rd_is_last;

  assign is_final   = byte_count >= ffcrc8_pkg::COUNT_W'(ffcrc8_pkg::PAYLOAD_BYTES);
  assign out_free   = !out_valid || m_tready;
  assign in_xfer    = s_tvalid && s_tready;
  assign rd_is_last = rd_idx == ffcrc8_pkg::ADDR_W'(ffcrc8_pkg::PAYLOAD_BYTES - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ffcrc8_pkg::ST_RECV;
      byte_count  <= '0;
      running_crc <= '0;
      rd_idx      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      byte_count  <= byte_count_next;
      running_crc <= running_crc_next;
      rd_idx      <= rd_idx_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte  <= out_byte_next;
    out_index <= out_index_next;
    out_last  <= out_last_next;
    out_bad   <= out_bad_next;
  end

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer && !is_final) begin
      frame_store[byte_count[ffcrc8_pkg::ADDR_W-1:0]] <= s_tdata;
    end
    rd_data <= frame_store[rd_idx];
  end

  always_comb begin
    state_next       = state;
    byte_count_next  = byte_count;
    running_crc_next = running_crc;
    rd_idx_next      = rd_idx;
    out_valid_next   = out_valid && !m_tready;
    out_byte_next    = out_byte;
    out_index_next   = out_index;
    out_last_next    = out_last;
    out_bad_next     = out_bad;
    s_tready         = 1'b0;

    unique case (state)
      ffcrc8_pkg::ST_RECV: begin
        s_tready = !is_final || out_free;
        if (in_xfer) begin
          if (is_final) begin
            byte_count_next  = '0;
            running_crc_next = '0;
            if (s_tdata == running_crc) begin
              rd_idx_next = '0;
              state_next  = ffcrc8_pkg::ST_READ;
            end else begin
              out_valid_next = 1'b1;
              out_byte_next  = '0;
              out_index_next = '0;
              out_last_next  = 1'b1;
              out_bad_next   = 1'b1;
            end
          end else begin
            byte_count_next  = byte_count + 1'b1;
            running_crc_next = ffcrc8_pkg::crc8_byte(running_crc ^ s_tdata);
          end
        end
      end
      ffcrc8_pkg::ST_READ: begin
        state_next = ffcrc8_pkg::ST_SEND;
      end
      ffcrc8_pkg::ST_SEND: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = rd_data;
          out_index_next = ffcrc8_pkg::COUNT_W'(rd_idx);
          out_last_next  = rd_is_last;
          out_bad_next   = 1'b0;
          if (rd_is_last) begin
            state_next = ffcrc8_pkg::ST_RECV;
          end else begin
            rd_idx_next = rd_idx + 1'b1;
            state_next  = ffcrc8_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = ffcrc8_pkg::ST_RECV;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_index, out_byte};
  assign m_tlast  = out_last;
  assign m_tuser  = out_bad;

endmodule

### rtl/ffcrc8_chk.sv
module ffcrc8_chk (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [ffcrc8_pkg::BYTE_W-1:0]       s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [ffcrc8_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                                m_tlast,
  input logic                                m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled output changed");

  // error result is a single zero transfer closing the frame
  a_bad_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata == '0)
    else $error("bad crc result malformed");

  // good frame ends on the last payload position
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tlast
      |-> m_tdata[13:8] == ffcrc8_pkg::COUNT_W'(ffcrc8_pkg::PAYLOAD_BYTES - 1))
    else $error("last flag on wrong byte index");

  // payload positions step by one within a good frame
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast ##1 m_tvalid
      |-> m_tdata[13:8] == $past(m_tdata[13:8]) + 1'b1 && !m_tuser)
    else $error("byte index out of sequence");

endmodule

bind fixed_frame_crc8_receiver ffcrc8_chk u_ffcrc8_chk (.*);
